@@ src/fcr_pkg.sv @@
// shared types and constants of the framed command receiver
package fcr_pkg;

  // frame layout
  localparam int unsigned FrameLen = 10;
  localparam logic [7:0]  StartMark = 8'd7;
  localparam logic [7:0]  StopMark = 8'd8;

  // size of the parameter table addressed by non-negative indices
  localparam logic [31:0] ParamCount = 32'd16;

  // lowest special index (-3) as an unsigned word
  localparam logic [31:0] SpecialLow = 32'hFFFF_FFFD;

  // single-float bit pattern of 0.5
  localparam logic [31:0] HalfFloatBits = 32'h3F00_0000;

  // slot that controls recording
  localparam logic [1:0] RecordSlot = 2'd2;

  // command kinds
  typedef enum logic [1:0] {
    KIND_PARAM   = 2'd0,
    KIND_SPECIAL = 2'd1,
    KIND_BAD     = 2'd2
  } cmd_kind_e;

  // decoded command handed from the front part to the back part
  typedef struct packed {
    cmd_kind_e   kind;
    logic [3:0]  param_index;
    logic [1:0]  special_slot;
    logic [31:0] value_bits;
  } cmd_t;

  // result item as delivered on the output side
  typedef struct packed {
    cmd_kind_e   kind;
    logic [3:0]  param_index;
    logic [1:0]  special_slot;
    logic [31:0] value_bits;
    logic        record_on;
    logic        dump_request;
  } result_t;

endpackage

@@ src/fcr_front.sv @@
// front part: byte window, frame detection and index decode
module fcr_front import fcr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o
);

  logic [7:0] window_q [FrameLen];
  logic [7:0] window_d [FrameLen];
  logic [3:0] count_q, count_d;
  logic       frame_hit;
  logic [31:0] idx;
  logic [31:0] val;

  // window shifts towards entry 0, newest byte enters at the top
  always_comb begin
    for (int i = 0; i < FrameLen - 1; i++) begin
      window_d[i] = window_q[i + 1];
    end
    window_d[FrameLen - 1] = rx_byte_i;
  end

  // frame is complete when enough bytes have come and both marks sit in place
  assign frame_hit = (count_q >= 4'(FrameLen - 1)) && (window_q[1] == StartMark) &&
                     (rx_byte_i == StopMark);

  // byte counter since the last frame, saturating at the frame length
  always_comb begin
    count_d = count_q;
    if (frame_hit) begin
      count_d = '0;
    end else if (count_q < 4'(FrameLen)) begin
      count_d = count_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < FrameLen; i++) begin
        window_q[i] <= '0;
      end
    end else if (byte_valid_i) begin
      count_q  <= count_d;
      window_q <= window_d;
    end
  end

  // little-endian index and value out of the completed window
  assign idx = {window_d[4], window_d[3], window_d[2], window_d[1]};
  assign val = {window_d[8], window_d[7], window_d[6], window_d[5]};

  // classify the index
  always_comb begin
    cmd_o.kind         = KIND_BAD;
    cmd_o.param_index  = '0;
    cmd_o.special_slot = '0;
    cmd_o.value_bits   = val;
    if (idx < ParamCount) begin
      cmd_o.kind        = KIND_PARAM;
      cmd_o.param_index = idx[3:0];
    end else if (idx >= SpecialLow) begin
      cmd_o.kind         = KIND_SPECIAL;
      cmd_o.special_slot = ~idx[1:0];
    end
  end

  assign cmd_valid_o = byte_valid_i && frame_hit;

endmodule

@@ src/fcr_queue.sv @@
// short command queue between the front and back parts
module fcr_queue import fcr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t pop_cmd_o
);

  localparam int unsigned Depth = 4;

  cmd_t       store_q [Depth];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] fill_q;

  assign full_o    = (fill_q == 3'(Depth));
  assign valid_o   = (fill_q != '0);
  assign pop_cmd_o = store_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 2'd1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 3'd1;
        2'b01:   fill_q <= fill_q - 3'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

@@ src/fcr_back.sv @@
// back part: special slots, recording flag and output register
module fcr_back import fcr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  output logic    res_valid_o,
  input  logic    res_ready_i,
  output result_t res_o
);

  logic [31:0] special_q [3];
  logic        record_q, record_d;
  logic        dump;
  logic        out_valid_q;
  result_t     out_q;

  function automatic logic f_is_nan(input logic [31:0] x);
    return x[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic f_equal(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (f_is_nan(a) || f_is_nan(b)) begin
      r = 1'b0;
    end else if ((a[30:0] | b[30:0]) == '0) begin
      r = 1'b1;
    end else begin
      r = (a == b);
    end
    return r;
  endfunction

  function automatic logic f_above_half(input logic [31:0] a);
    return !f_is_nan(a) && !a[31] && (a > HalfFloatBits);
  endfunction

  // take a command when the output register is free or being emptied
  assign cmd_pop_o = cmd_valid_i && (!out_valid_q || res_ready_i);

  // recording control on a changed write to the record slot
  always_comb begin
    record_d = record_q;
    dump     = 1'b0;
    if (cmd_i.kind == KIND_SPECIAL && cmd_i.special_slot == RecordSlot &&
        !f_equal(cmd_i.value_bits, special_q[RecordSlot])) begin
      if (f_above_half(cmd_i.value_bits)) begin
        record_d = 1'b1;
      end else begin
        record_d = 1'b0;
        dump     = 1'b1;
      end
    end
  end

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        special_q[i] <= '0;
      end
    end else if (cmd_pop_o) begin
      record_q <= record_d;
      if (cmd_i.kind == KIND_SPECIAL) begin
        special_q[cmd_i.special_slot] <= cmd_i.value_bits;
      end
    end
  end

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_q.kind         <= cmd_i.kind;
      out_q.param_index  <= cmd_i.param_index;
      out_q.special_slot <= cmd_i.special_slot;
      out_q.value_bits   <= cmd_i.value_bits;
      out_q.record_on    <= record_d;
      out_q.dump_request <= dump;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

@@ src/framed_command_receiver_core.sv @@
// top level of the framed command receiver
// result path: a completed frame's command is registered in the command queue and then in the
//   output register before the earliest result handshake, when both are empty
// throughput: one byte per cycle; the byte window and index compare take a byte each cycle,
//   and the four-entry command queue stalls input only while full
// reset: asynchronous, clears the window, byte count, special slots, recording flag, queue
//   and output valid
module framed_command_receiver_core import fcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // param_index[3:0], special_slot[5:4], value_bits[37:6],
                                      // record_on[38], dump_request[39]
  output logic [1:0]  m_axis_tuser    // command_kind[1:0]
);

  logic    byte_accept;
  logic    front_valid;
  cmd_t    front_cmd;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  cmd_t    q_cmd;
  result_t res;

  assign s_axis_tready = !q_full;
  assign byte_accept   = s_axis_tvalid && s_axis_tready;

  // front part
  fcr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_accept),
    .rx_byte_i    (s_axis_tdata),
    .cmd_valid_o  (front_valid),
    .cmd_o        (front_cmd)
  );

  // command queue
  fcr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (front_valid),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (q_cmd)
  );

  // back part
  fcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // output packing
  assign m_axis_tuser = res.kind;
  assign m_axis_tdata = {res.dump_request, res.record_on, res.value_bits,
                         res.special_slot, res.param_index};

  // no push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(front_valid && q_full))
    else $error("command pushed into full queue");

  // a dump request always leaves recording off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[39]) |-> !m_axis_tdata[38])
    else $error("dump request with recording on");

  // bad index results carry neither parameter index nor slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_BAD) |-> (m_axis_tdata[5:0] == 6'd0))
    else $error("bad index item carries index or slot");

  // recording flag moves only through a popped command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_pop |=> $stable(u_back.record_q))
    else $error("recording flag changed without a command");

endmodule

@@ bench/tb.sv @@
// testbench of the framed command receiver: byte stream in, decoded commands checked
module tb;
  import fcr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned RandomBytes = 800;

  // one byte waiting to be sent; drain holds it back until no command is outstanding
  typedef struct {
    logic [7:0] data;
    bit         drain;
  } rx_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // rx_byte[7:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;          // param_index[3:0], special_slot[5:4], value_bits[37:6],
                                      // record_on[38], dump_request[39]
  logic [1:0]  m_axis_tuser;          // command_kind[1:0]

  rx_item_t    pending_bytes[$];
  result_t     expected_cmds[$];
  int unsigned bytes_total;
  int unsigned bytes_taken = 0;
  int unsigned fails = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned idle_cycles = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;

  // predictor state
  logic [7:0]  rx_window[FrameLen];
  int unsigned frame_fill = 0;
  logic [31:0] slot_value[3];
  logic        recording = 1'b0;

  // float patterns around the recording threshold and the odd cases
  logic [31:0] float_picks[12] = '{
    32'h3F00_0000, 32'h3F00_0001, 32'h3EFF_FFFF, 32'h3F80_0000,
    32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000, 32'hFFC0_0000,
    32'h7F80_0000, 32'hFF80_0000, 32'hBF80_0000, 32'h7F80_0001
  };

  framed_command_receiver_core uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // float helpers on raw single-precision bits
  function automatic bit is_nan(input logic [31:0] f);
    return (f & 32'h7FFF_FFFF) > 32'h7F80_0000;
  endfunction

  function automatic bit float_same(input logic [31:0] a, input logic [31:0] b);
    if (is_nan(a) || is_nan(b)) return 1'b0;
    if (((a | b) & 32'h7FFF_FFFF) == 32'd0) return 1'b1;
    return a == b;
  endfunction

  function automatic bit above_half(input logic [31:0] f);
    if (is_nan(f) || f[31]) return 1'b0;
    return f > HalfFloatBits;
  endfunction

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // shift a byte into the window and decode a frame when one completes
  task automatic take_rx_byte(input logic [7:0] b);
    logic [31:0] idx;
    logic [31:0] val;
    logic [1:0]  slot;
    result_t     cmd;
    for (int i = 0; i < FrameLen - 1; i++) rx_window[i] = rx_window[i + 1];
    rx_window[FrameLen - 1] = b;
    if (frame_fill < FrameLen) frame_fill++;
    if (frame_fill < FrameLen || rx_window[0] != StartMark ||
        rx_window[FrameLen - 1] != StopMark) return;
    frame_fill = 0;
    idx = {rx_window[4], rx_window[3], rx_window[2], rx_window[1]};
    val = {rx_window[8], rx_window[7], rx_window[6], rx_window[5]};
    cmd.kind = KIND_BAD;
    cmd.param_index = '0;
    cmd.special_slot = '0;
    cmd.value_bits = val;
    cmd.dump_request = 1'b0;
    if (idx < ParamCount) begin
      cmd.kind = KIND_PARAM;
      cmd.param_index = idx[3:0];
    end else if (idx >= SpecialLow) begin
      slot = ~idx[1:0];
      cmd.kind = KIND_SPECIAL;
      cmd.special_slot = slot;
      // only a changed value on the record slot moves the recording flag
      if (slot == RecordSlot && !float_same(val, slot_value[RecordSlot])) begin
        if (above_half(val)) begin
          recording = 1'b1;
        end else begin
          recording = 1'b0;
          cmd.dump_request = 1'b1;
        end
      end
      slot_value[slot] = val;
    end
    cmd.record_on = recording;
    expected_cmds.push_back(cmd);
  endtask

  // compare one delivered command with the oldest prediction
  task automatic check_command();
    result_t want;
    if (expected_cmds.size() == 0) begin
      $error("unexpected command: kind %0d data %h", m_axis_tuser, m_axis_tdata);
      fails++;
      return;
    end
    want = expected_cmds.pop_front();
    if (m_axis_tuser !== want.kind) begin
      $error("command_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
      fails++;
    end
    if (m_axis_tdata[3:0] !== want.param_index) begin
      $error("param_index: expected %0d, got %0d", want.param_index, m_axis_tdata[3:0]);
      fails++;
    end
    if (m_axis_tdata[5:4] !== want.special_slot) begin
      $error("special_slot: expected %0d, got %0d", want.special_slot, m_axis_tdata[5:4]);
      fails++;
    end
    if (m_axis_tdata[37:6] !== want.value_bits) begin
      $error("value_bits: expected %h, got %h", want.value_bits, m_axis_tdata[37:6]);
      fails++;
    end
    if (m_axis_tdata[38] !== want.record_on) begin
      $error("record_on: expected %0d, got %0d", want.record_on, m_axis_tdata[38]);
      fails++;
    end
    if (m_axis_tdata[39] !== want.dump_request) begin
      $error("dump_request: expected %0d, got %0d", want.dump_request, m_axis_tdata[39]);
      fails++;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b, input bit drain = 1'b0);
    rx_item_t it;
    it.data = b;
    it.drain = drain;
    pending_bytes.push_back(it);
  endtask

  // start mark, little-endian index, little-endian value, stop mark
  task automatic queue_frame(input logic [31:0] idx, input logic [31:0] val,
                             input bit drain = 1'b0);
    queue_byte(StartMark, drain);
    for (int i = 0; i < 4; i++) queue_byte(idx[8*i +: 8]);
    for (int i = 0; i < 4; i++) queue_byte(val[8*i +: 8]);
    queue_byte(StopMark);
  endtask

  function automatic logic [31:0] pick_value();
    return ($urandom_range(0, 2) == 0) ? $urandom() : float_picks[$urandom_range(0, 11)];
  endfunction

  function automatic logic [31:0] pick_index();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom_range(0, 15);
      2:       return -$urandom_range(1, 2);
      3, 4, 5: return -32'sd3;
      6:       return ($urandom_range(0, 1) == 0) ? ParamCount : -32'sd4;
      default: return $urandom();
    endcase
  endfunction

  // byte sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      send_wait <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        take_rx_byte(s_axis_tdata);
        bytes_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait != 0) begin
          s_axis_tvalid <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].drain && expected_cmds.size() != 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_bytes[0].data;
          void'(pending_bytes.pop_front());
          send_wait <= draw_wait(send_calm);
          if ($urandom_range(0, 39) == 0) send_calm <= !send_calm;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // command receiver with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      check_command();
      stall = draw_wait(recv_calm);
      if ($urandom_range(0, 39) == 0) recv_calm <= !recv_calm;
      recv_wait <= stall;
      m_axis_tready <= (stall == 0);
    end else if (recv_wait != 0) begin
      recv_wait <= recv_wait - 1;
      m_axis_tready <= (recv_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned len;
    logic [7:0]  part[FrameLen];
    for (int i = 0; i < FrameLen; i++) rx_window[i] = '0;
    for (int i = 0; i < 3; i++) slot_value[i] = '0;

    // directed: index edges, every slot, recording transitions and float corner cases
    queue_frame(32'd0, 32'd0);
    queue_frame(32'd15, 32'hFFFF_FFFF);
    queue_frame(ParamCount, 32'h1234_5678);
    queue_frame(-32'sd4, 32'h0000_0001);
    queue_frame(32'h7FFF_FFFF, 32'h8000_0000);
    queue_frame(32'h8000_0000, 32'h5A5A_A5A5);
    queue_frame(-32'sd1, 32'hC0DE_0001);
    queue_frame(-32'sd2, 32'hC0DE_0002);
    queue_frame(-32'sd3, 32'h3F80_0000);
    queue_frame(-32'sd3, 32'h3F80_0000, 1'b1);
    queue_frame(-32'sd3, 32'h3F00_0000);
    queue_frame(-32'sd3, 32'h3F00_0001);
    queue_frame(-32'sd3, 32'h7FC0_0000);
    queue_frame(-32'sd3, 32'h7FC0_0000);
    queue_frame(-32'sd3, 32'h0000_0000);
    queue_frame(-32'sd3, 32'h8000_0000);
    queue_frame(-32'sd3, 32'hBF80_0000);
    queue_frame(-32'sd3, 32'h7F80_0000);
    // stop mark too early after a start mark, then a well-formed frame followed by a stray byte and stop mark
    queue_byte(StartMark);
    queue_byte(StopMark);
    queue_frame(32'd3, 32'd9);
    queue_byte(8'hFF);
    queue_byte(StopMark);
    // index byte equal to the start mark must not be reused by a following stop mark
    queue_frame(32'd7, 32'h0000_0007);
    queue_byte(StopMark);

    // random: mostly well-formed frames, some noise, broken frames and mark bursts
    queue_frame(pick_index(), pick_value(), 1'b1);
    while (pending_bytes.size() < RandomBytes) begin
      case ($urandom_range(0, 9))
        7: begin
          len = $urandom_range(1, 6);
          repeat (len) queue_byte(8'($urandom_range(0, 255)));
        end
        8: begin
          part[0] = StartMark;
          for (int i = 1; i < FrameLen - 1; i++) part[i] = 8'($urandom_range(0, 255));
          part[FrameLen - 1] = StopMark;
          part[$urandom_range(0, FrameLen - 1)] = 8'($urandom_range(0, 255));
          len = $urandom_range(1, FrameLen);
          for (int i = 0; i < len; i++) queue_byte(part[i]);
        end
        9: begin
          len = $urandom_range(3, 12);
          repeat (len) queue_byte(($urandom_range(0, 1) == 0) ? StartMark : StopMark);
        end
        default: queue_frame(pick_index(), pick_value(), $urandom_range(0, 19) == 0);
      endcase
    end
    bytes_total = pending_bytes.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for the stream to drain, then let the pipeline settle
    while (bytes_taken != bytes_total) @(posedge clk_i);
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_cmds.size() != 0) begin
      $error("%0d commands never delivered", expected_cmds.size());
      fails++;
    end
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ framed_command_receiver_core.f @@
src/fcr_pkg.sv
src/fcr_front.sv
src/fcr_queue.sv
src/fcr_back.sv
src/framed_command_receiver_core.sv
bench/tb.sv
